FILE: src/ppsw_pkg.sv
// ppsw_pkg: shared constants, register indexes, opcodes and the controller
// command bundle for the ping-pong path block; no dependencies
`default_nettype none

package ppsw_pkg;

  localparam int PFB = 24;
  localparam int PW = PFB + 1;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WAVES = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_X = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y = 3'd7;

  localparam logic [2:0] MUL_HOLD = 3'd0;
  localparam logic [2:0] MUL_DX = 3'd1;
  localparam logic [2:0] MUL_DY = 3'd2;
  localparam logic [2:0] MUL_GX = 3'd3;
  localparam logic [2:0] MUL_GY = 3'd4;

  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_BASE_X = 2'd1;
  localparam logic [1:0] ACC_BASE_Y = 2'd2;
  localparam logic [1:0] ACC_LAT_X = 2'd3;

  typedef struct packed {
    logic       step;
    logic [2:0] mul_op;
    logic [1:0] acc_op;
    logic       out_load;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

FILE: src/ppsw_if.sv
// ppsw_if: valid/ready channels for tick items and result items
// depends on ppsw_pkg
`default_nettype none

interface ppsw_tick_if;
  import ppsw_pkg::*;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface ppsw_result_if;
  import ppsw_pkg::*;
  logic                valid;
  logic                ready;
  logic signed [31:0]  pos_x;
  logic signed [31:0]  pos_y;
  logic [PW-1:0]       path_progress;
  logic                moving_back;
  modport source (output valid, output pos_x, output pos_y, output path_progress,
                  output moving_back, input ready);
  modport sink (input valid, input pos_x, input pos_y, input path_progress,
                input moving_back, output ready);
endinterface

`default_nettype wire

FILE: src/pingpong_path_with_sine_weave.sv
// Ping-pong path follower with a sine weave across the path.
// Channels: tick (sink) carries restart; result (source) carries pos_x,
// pos_y (signed Q16.16, saturated), path_progress (Q1.24, 1.0 = end) and
// moving_back. The user must write the registers (cfg_write / cfg_index /
// cfg_data) only while no item is in flight; the block does not check it.
// Each accepted tick moves the progress one step (or back to the start on
// restart) and yields exactly one result item.
// The sequencer runs four products through the single shared multiplier,
// one per cycle, in its MULX, MULY, MULGX and MULGY steps, then loads the
// result register in FIN; a new tick is taken only once FIN is left.
// The sine rom read is registered and overlaps the first two products.
// When the receiver stalls, the finished result holds in the output
// register and the sequencer waits in its last step before taking a new
// tick. Reset loads the configuration registers with their defaults, puts
// the progress at the start moving forward, and leaves no result pending.
// depends on ppsw_pkg, ppsw_if, ppsw_ctrl, ppsw_datapath
`default_nettype none

module pingpong_path_with_sine_weave #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [ppsw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ppsw_pkg::CFG_W-1:0]     cfg_data,
  ppsw_tick_if.sink                      tick,
  ppsw_result_if.source                  result
);
  import ppsw_pkg::*;

  ctrl_cmd_t cmd;

  ppsw_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick.valid),
    .tick_ready   (tick.ready),
    .result_ready (result.ready),
    .result_valid (result.valid),
    .cmd          (cmd)
  );

  ppsw_datapath #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .restart       (tick.restart),
    .cmd           (cmd),
    .pos_x         (result.pos_x),
    .pos_y         (result.pos_y),
    .path_progress (result.path_progress),
    .moving_back   (result.moving_back)
  );

endmodule

`default_nettype wire

FILE: src/ppsw_ctrl.sv
// ppsw_ctrl: sequencer that steps the datapath through one tick and owns
// the handshake flags; depends on ppsw_pkg
`default_nettype none

module ppsw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tick_valid,
  output logic                 tick_ready,
  input  logic                 result_ready,
  output logic                 result_valid,
  output ppsw_pkg::ctrl_cmd_t  cmd
);
  import ppsw_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MULX = 3'd1;
  localparam logic [2:0] S_MULY = 3'd2;
  localparam logic [2:0] S_MULGX = 3'd3;
  localparam logic [2:0] S_MULGY = 3'd4;
  localparam logic [2:0] S_FIN = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign tick_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (tick_valid) begin
          cmd.step = 1'b1;
          state_next = S_MULX;
        end
      end
      S_MULX: begin
        cmd.mul_op = MUL_DX;
        state_next = S_MULY;
      end
      S_MULY: begin
        cmd.acc_op = ACC_BASE_X;
        cmd.mul_op = MUL_DY;
        state_next = S_MULGX;
      end
      S_MULGX: begin
        cmd.acc_op = ACC_BASE_Y;
        cmd.mul_op = MUL_GX;
        state_next = S_MULGY;
      end
      S_MULGY: begin
        cmd.acc_op = ACC_LAT_X;
        cmd.mul_op = MUL_GY;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!result_valid || result_ready) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!result_valid || result_ready))
    else $error("result overwritten while stalled");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && tick_ready) |=> (state == S_MULX))
    else $error("accepted item did not start the sequence");

  a_valid_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == S_FIN))
    else $error("result raised outside the final step");
`endif

endmodule

`default_nettype wire

FILE: src/ppsw_datapath.sv
// ppsw_datapath: config registers, progress update, sine rom, shared
// multiplier, accumulators and result register; depends on ppsw_pkg
`default_nettype none

module ppsw_datapath #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [ppsw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ppsw_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          restart,
  input  ppsw_pkg::ctrl_cmd_t           cmd,
  output logic signed [31:0]            pos_x,
  output logic signed [31:0]            pos_y,
  output logic [ppsw_pkg::PW-1:0]       path_progress,
  output logic                          moving_back
);
  import ppsw_pkg::*;

  localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);
  localparam int IDX_W = ADDR_W + 2;
  localparam int MA_W = 33;
  localparam int PROD_W = MA_W + PW;
  localparam int ACC_W = 37;
  localparam logic [PW:0] ONE_EXT = (PW + 1)'(1) << PFB;
  localparam logic [PFB-1:0] HALF = PFB'(1) << (PFB - 1);
  localparam logic [PFB:0] IDX_ROUND = (PFB + 1)'(1) << (PFB - IDX_W - 1);
  localparam logic [PROD_W:0] RND24 = (PROD_W + 1)'(1) << (PFB - 1);
  localparam logic [PROD_W:0] RND16 = (PROD_W + 1)'(1) << 15;
  localparam logic signed [ACC_W-1:0] SAT_HI = 37'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_LO = -37'sd2147483648;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  function automatic logic [15:0] sine_entry(input int unsigned idx);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    x = (HALF_PI_Q30 * 64'(idx)) / SINE_TABLE_DEPTH;
    x2 = (x * x) >> 30;
    t = Q30_ONE;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s = (x * t) >> 30;
    r = (s + 64'd8192) >> 14;
    return (r > 64'd65535) ? 16'hFFFF : r[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = v;
    if (v > SAT_HI) c = SAT_HI;
    if (v < SAT_LO) c = SAT_LO;
    return c[31:0];
  endfunction

  // configuration
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic [PW-1:0]      progress_step;
  logic [3:0]         wave_count;
  logic signed [31:0] lateral_x_gain;
  logic signed [31:0] lateral_y_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_y <= '0;
      end_x <= 32'sd65536;
      end_y <= '0;
      progress_step <= PW'(3355);
      wave_count <= 4'd1;
      lateral_x_gain <= '0;
      lateral_y_gain <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_START_X: start_x <= cfg_data;
        REG_START_Y: start_y <= cfg_data;
        REG_END_X:   end_x <= cfg_data;
        REG_END_Y:   end_y <= cfg_data;
        REG_STEP:    progress_step <= cfg_data[PW-1:0];
        REG_WAVES:   wave_count <= cfg_data[3:0];
        REG_GAIN_X:  lateral_x_gain <= cfg_data;
        REG_GAIN_Y:  lateral_y_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // progress and direction
  logic [PW-1:0] progress;
  logic          reverse_flag;
  logic [PW:0]   fwd_sum;

  assign fwd_sum = {1'b0, progress} + {1'b0, progress_step};

  always_ff @(posedge clk) begin
    if (rst) begin
      progress <= '0;
      reverse_flag <= 1'b0;
    end else if (cmd.step) begin
      if (restart) begin
        progress <= '0;
        reverse_flag <= 1'b0;
      end else if (!reverse_flag) begin
        if (fwd_sum > ONE_EXT) begin
          progress <= ONE_EXT[PW-1:0];
          reverse_flag <= 1'b1;
        end else begin
          progress <= fwd_sum[PW-1:0];
        end
      end else begin
        if (progress_step > progress) begin
          progress <= '0;
          reverse_flag <= 1'b0;
        end else begin
          progress <= progress - progress_step;
        end
      end
    end
  end

  // sine phase and rom
  logic [PFB-1:0]    phase_off;
  logic [PFB+3:0]    phase_mul;
  logic [PFB:0]      idx_sum;
  logic [IDX_W-1:0]  sine_idx;
  logic [ADDR_W-1:0] sine_r;
  logic [ADDR_W-1:0] sine_r_neg;
  logic [ADDR_W-1:0] rom_addr;
  logic [15:0]       rom_q;
  logic              quad_neg;
  logic              peak;
  logic [16:0]       s_mag;
  logic [15:0]       sine_rom [SINE_TABLE_DEPTH];

  for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_rom
    assign sine_rom[i] = sine_entry(i);
  end

  assign phase_off = progress[PFB-1:0] - HALF;
  assign phase_mul = (PFB + 4)'(phase_off) * (PFB + 4)'(wave_count);
  assign idx_sum = {1'b0, phase_mul[PFB-1:0]} + IDX_ROUND;
  assign sine_idx = idx_sum[PFB-1:PFB-IDX_W];
  assign sine_r = sine_idx[ADDR_W-1:0];
  assign sine_r_neg = ~sine_r + 1'b1;
  assign s_mag = peak ? 17'h10000 : {1'b0, rom_q};

  always_ff @(posedge clk) begin
    if (cmd.mul_op == MUL_DX) begin
      rom_addr <= sine_idx[IDX_W-2] ? sine_r_neg : sine_r;
      quad_neg <= sine_idx[IDX_W-1];
      peak <= sine_idx[IDX_W-2] && (sine_r == '0);
    end
    rom_q <= sine_rom[rom_addr];
  end

  // shared multiplier on magnitudes
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic [MA_W-1:0]    dx_mag;
  logic [MA_W-1:0]    dy_mag;
  logic [31:0]        gx_mag;
  logic [31:0]        gy_mag;
  logic [MA_W-1:0]    mul_a;
  logic [PW-1:0]      mul_b;
  logic               mul_neg;
  logic [PROD_W-1:0]  prod;
  logic               prod_neg;

  assign dx = $signed({end_x[31], end_x}) - $signed({start_x[31], start_x});
  assign dy = $signed({end_y[31], end_y}) - $signed({start_y[31], start_y});
  assign dx_mag = dx[32] ? (~dx + 1'b1) : dx;
  assign dy_mag = dy[32] ? (~dy + 1'b1) : dy;
  assign gx_mag = lateral_x_gain[31] ? (~lateral_x_gain + 1'b1) : lateral_x_gain;
  assign gy_mag = lateral_y_gain[31] ? (~lateral_y_gain + 1'b1) : lateral_y_gain;

  always_comb begin
    mul_a = dx_mag;
    mul_b = progress;
    mul_neg = dx[32];
    case (cmd.mul_op)
      MUL_DY: begin
        mul_a = dy_mag;
        mul_neg = dy[32];
      end
      MUL_GX: begin
        mul_a = MA_W'(gx_mag);
        mul_b = PW'(s_mag);
        mul_neg = lateral_x_gain[31] ^ quad_neg;
      end
      MUL_GY: begin
        mul_a = MA_W'(gy_mag);
        mul_b = PW'(s_mag);
        mul_neg = lateral_y_gain[31] ^ quad_neg;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_op != MUL_HOLD) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
      prod_neg <= mul_neg;
    end
  end

  // rounding, half away from zero
  logic [PROD_W:0]         sum24;
  logic [PROD_W:0]         sum16;
  logic [ACC_W-1:0]        q24;
  logic [ACC_W-1:0]        q16;
  logic signed [ACC_W-1:0] term24;
  logic signed [ACC_W-1:0] term16;
  logic signed [ACC_W-1:0] acc_x;
  logic signed [ACC_W-1:0] acc_y;
  logic signed [ACC_W-1:0] y_final;

  assign sum24 = {1'b0, prod} + RND24;
  assign sum16 = {1'b0, prod} + RND16;
  assign q24 = ACC_W'(sum24[PROD_W:PFB]);
  assign q16 = ACC_W'(sum16[PROD_W:16]);
  assign term24 = prod_neg ? -$signed(q24) : $signed(q24);
  assign term16 = prod_neg ? -$signed(q16) : $signed(q16);
  assign y_final = acc_y + term16;

  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      ACC_BASE_X: acc_x <= ACC_W'(start_x) + term24;
      ACC_BASE_Y: acc_y <= ACC_W'(start_y) + term24;
      ACC_LAT_X:  acc_x <= acc_x + term16;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pos_x <= sat32(acc_x);
      pos_y <= sat32(y_final);
      path_progress <= progress;
      moving_back <= reverse_flag;
    end
  end

endmodule

`default_nettype wire
